@@ sv/btmx_pkg.sv @@
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types, widths and codes for the binary trie max-XOR core.
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int KEY_BITS   = 43;
  localparam int NODE_COUNT = 4096;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = NODE_W + 1;
  localparam int LVL_W      = $clog2(KEY_BITS);
  localparam int NEED_W     = CNT_W + 1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [LVL_W-1:0]    lvl_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_RESULT
  } state_e;

  typedef struct packed {
    node_t c1;
    node_t c0;
  } children_t;

  typedef struct packed {
    logic      en;
    node_t     addr;
    children_t data;
  } node_wr_t;

  typedef struct packed {
    key_t       max_xor;
    logic [1:0] status;
  } res_t;

  function automatic node_t child_sel(children_t ch, logic b);
    return b ? ch.c1 : ch.c0;
  endfunction

  function automatic children_t set_child(children_t ch, logic b, node_t n);
    children_t r;
    r = ch;
    if (b) r.c1 = n;
    else   r.c0 = n;
    return r;
  endfunction

endpackage

@@ sv/btmx_if.sv @@
// ----------------------------------------------------------------------------
// btmx channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface btmx_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [btmx_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface btmx_out_if;
  logic                          valid;
  logic                          ready;
  logic [btmx_pkg::KEY_BITS-1:0] max_xor;
  logic [1:0]                    status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

@@ sv/btmx_node_mem.sv @@
// ----------------------------------------------------------------------------
// btmx_node_mem
// Trie node memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btmx_node_mem (
  input  logic                clk_i,
  input  btmx_pkg::node_wr_t  wr_i,
  input  logic                rd_en_i,
  input  btmx_pkg::node_t     rd_addr_i,
  output btmx_pkg::children_t rd_data_o
);
  import btmx_pkg::*;

  children_t node_mem [NODE_COUNT];
  children_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      node_mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= node_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/btmx_out_reg.sv @@
// ----------------------------------------------------------------------------
// btmx_out_reg
// Output register for result words; decouples the core from the sink.
// ----------------------------------------------------------------------------
module btmx_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  btmx_pkg::res_t    data_i,
  output logic              free_o,
  btmx_out_if.source        out_o
);
  import btmx_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = push_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.max_xor = data_q.max_xor;
  assign out_o.status  = data_q.status;

endmodule

@@ sv/binary_trie_max_xor_core.sv @@
// A query takes one walk step per trie level from accept to result word;
// the root level reads a register, each lower level one node memory read.
// An insert walks to the first missing child, then, if the pool has room, writes one
// node per cycle. One word is in flight; the next is accepted the cycle
// after the previous result has moved into the output register.
// Reset: root children clear, node count goes to 1 at once; no memory clearing pass.
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core
// Binary trie of keys in a node memory with insert and max-XOR query.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_core (
  input logic        clk_i,
  input logic        rst_ni,
  btmx_in_if.sink    in_i,
  btmx_out_if.source out_o
);
  import btmx_pkg::*;

  state_e    state_q, state_d;
  logic      has_keys_q, has_keys_d;
  cnt_t      nu_q, nu_d;
  children_t root_q, root_d;

  opcode_e   op_q, op_d;
  key_t      key_q, key_d;
  lvl_t      lvl_q, lvl_d;
  node_t     node_q, node_d;
  logic      cur_root_q, cur_root_d;
  key_t      acc_q, acc_d;
  children_t div_ch_q, div_ch_d;
  logic      first_q, first_d;
  logic      leaf_q, leaf_d;
  res_t      res_q, res_d;

  node_wr_t  wr;
  logic      rd_en;
  node_t     rd_addr;
  children_t rd_data;
  logic      push;
  logic      out_free;

  children_t      cur_ch;
  children_t      base_ch;
  children_t      new_ch;
  logic           bit_k;
  node_t          c_same;
  node_t          c_want;
  node_t          nxt;
  logic [NEED_W-1:0] need_sum;

  btmx_node_mem u_node_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  btmx_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res_q),
    .free_o (out_free),
    .out_o  (out_o)
  );

  assign cur_ch   = cur_root_q ? root_q : rd_data;
  assign bit_k    = key_q[lvl_q];
  assign c_same   = child_sel(cur_ch, bit_k);
  assign c_want   = child_sel(cur_ch, !bit_k);
  assign nxt      = (c_want != '0) ? c_want : c_same;
  assign need_sum = NEED_W'(nu_q) + NEED_W'(lvl_q) + NEED_W'(1);
  assign base_ch  = first_q ? div_ch_q : '0;
  assign new_ch   = set_child(base_ch, bit_k, nu_q[NODE_W-1:0]);

  always_comb begin
    state_d    = state_q;
    has_keys_d = has_keys_q;
    nu_d       = nu_q;
    root_d     = root_q;
    op_d       = op_q;
    key_d      = key_q;
    lvl_d      = lvl_q;
    node_d     = node_q;
    cur_root_d = cur_root_q;
    acc_d      = acc_q;
    div_ch_d   = div_ch_q;
    first_d    = first_q;
    leaf_d     = leaf_q;
    res_d      = res_q;
    wr         = '0;
    rd_en      = 1'b0;
    rd_addr    = node_q;
    push       = 1'b0;
    in_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d       = opcode_e'(in_i.opcode);
          key_d      = in_i.key;
          lvl_d      = LVL_W'(KEY_BITS - 1);
          node_d     = '0;
          cur_root_d = 1'b1;
          acc_d      = '0;
          if (opcode_e'(in_i.opcode) == OP_QUERY && !has_keys_q) begin
            res_d   = '{max_xor: '0, status: ST_EMPTY};
            state_d = S_RESULT;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (op_q == OP_INSERT) begin
          if (c_same == '0) begin
            // free-pool check before any node is touched
            if (need_sum > NEED_W'(NODE_COUNT)) begin
              res_d   = '{max_xor: '0, status: ST_FULL};
              state_d = S_RESULT;
            end else begin
              div_ch_d = cur_ch;
              first_d  = 1'b1;
              leaf_d   = 1'b0;
              state_d  = S_ALLOC;
            end
          end else if (lvl_q == '0) begin
            res_d   = '{max_xor: '0, status: ST_OK};
            state_d = S_RESULT;
          end else begin
            node_d     = c_same;
            lvl_d      = lvl_q - LVL_W'(1);
            cur_root_d = 1'b0;
            rd_en      = 1'b1;
            rd_addr    = c_same;
          end
        end else begin
          if (c_want != '0) begin
            acc_d[lvl_q] = 1'b1;
          end
          if (nxt == '0 || lvl_q == '0) begin
            res_d   = '{max_xor: acc_d, status: ST_OK};
            state_d = S_RESULT;
          end else begin
            node_d     = nxt;
            lvl_d      = lvl_q - LVL_W'(1);
            cur_root_d = 1'b0;
            rd_en      = 1'b1;
            rd_addr    = nxt;
          end
        end
      end

      S_ALLOC: begin
        if (leaf_q) begin
          wr         = '{en: 1'b1, addr: node_q, data: '0};
          has_keys_d = 1'b1;
          res_d      = '{max_xor: '0, status: ST_OK};
          state_d    = S_RESULT;
        end else begin
          // link the next fresh node below the current one
          if (node_q == '0) begin
            root_d = new_ch;
          end else begin
            wr = '{en: 1'b1, addr: node_q, data: new_ch};
          end
          node_d  = nu_q[NODE_W-1:0];
          nu_d    = nu_q + CNT_W'(1);
          first_d = 1'b0;
          if (lvl_q == '0) begin
            leaf_d = 1'b1;
          end else begin
            lvl_d = lvl_q - LVL_W'(1);
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      has_keys_q <= 1'b0;
      nu_q       <= CNT_W'(1);
      root_q     <= '0;
    end else begin
      state_q    <= state_d;
      has_keys_q <= has_keys_d;
      nu_q       <= nu_d;
      root_q     <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    lvl_q      <= lvl_d;
    node_q     <= node_d;
    cur_root_q <= cur_root_d;
    acc_q      <= acc_d;
    div_ch_q   <= div_ch_d;
    first_q    <= first_d;
    leaf_q     <= leaf_d;
    res_q      <= res_d;
  end

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nu_q <= CNT_W'(NODE_COUNT))
    else $error("node count beyond pool");

  a_no_root_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> wr.addr != '0)
    else $error("root written through node memory");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!wr.en && !rd_en))
    else $error("memory access while idle");

  a_keys_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(has_keys_q))
    else $error("has_keys dropped");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res_q.status == ST_FULL) |-> res_q.max_xor == '0)
    else $error("dropped insert with nonzero result");

endmodule
